@@ rtl/nmea_ck_pkg.sv @@
`timescale 1ns / 1ps
// nmea_ck_pkg: shared types, character codes and the hex digit decoder
// for the nmea checksum checker; depends on nothing
package nmea_ck_pkg;

  // sentence framing characters
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChNul    = 8'h00;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MISMATCH  = 3'd1,
    ST_EARLY_END = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_BAD_HEX   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_BODY = 4'b0010,
    PH_HEX1 = 4'b0100,
    PH_HEX2 = 4'b1000
  } phase_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
    logic [6:0]  body_length;
  } verdict_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_t;

  // decode one ascii hex digit, either letter case
  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t r;
    r.bad   = 1'b0;
    r.value = 4'd0;
    if (c inside {[8'h30 : 8'h39]}) begin
      r.value = 4'(c - 8'h30);
    end else if (c inside {[8'h41 : 8'h46]}) begin
      r.value = 4'(c - 8'h41 + 8'd10);
    end else if (c inside {[8'h61 : 8'h66]}) begin
      r.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/nmea_ck_core.sv @@
`timescale 1ns / 1ps
// nmea_ck_core: sentence state machine, running xor and body counter;
// updates once per processed word; uses nmea_ck_pkg
module nmea_ck_core #(
  parameter int unsigned MAX_BODY = 80
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output logic                  verdict_valid_o,
  output nmea_ck_pkg::verdict_t verdict_o
);

  nmea_ck_pkg::phase_e phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [6:0] count_q, count_d;
  logic [3:0] nib_q, nib_d;
  nmea_ck_pkg::hex_t hex;

  assign hex = nmea_ck_pkg::hex_decode(byte_i);

  always_comb begin
    phase_d         = phase_q;
    xor_d           = xor_q;
    count_d         = count_q;
    nib_d           = nib_q;
    verdict_valid_o = 1'b0;
    verdict_o.status       = nmea_ck_pkg::ST_OK;
    verdict_o.computed_sum = xor_q;
    verdict_o.received_sum = 8'd0;
    verdict_o.body_length  = count_q;
    if (step_i) begin
      case (phase_q)
        nmea_ck_pkg::PH_HUNT: begin
          if (byte_i == nmea_ck_pkg::ChDollar) begin
            xor_d   = 8'd0;
            count_d = 7'd0;
            nib_d   = 4'd0;
            phase_d = nmea_ck_pkg::PH_BODY;
          end
        end
        nmea_ck_pkg::PH_BODY: begin
          if (byte_i == nmea_ck_pkg::ChStar) begin
            phase_d = nmea_ck_pkg::PH_HEX1;
          end else if (byte_i inside {nmea_ck_pkg::ChCr, nmea_ck_pkg::ChLf,
                                      nmea_ck_pkg::ChNul}) begin
            verdict_valid_o  = 1'b1;
            verdict_o.status = nmea_ck_pkg::ST_EARLY_END;
            phase_d          = nmea_ck_pkg::PH_HUNT;
          end else if (count_q >= 7'(MAX_BODY)) begin
            verdict_valid_o  = 1'b1;
            verdict_o.status = nmea_ck_pkg::ST_TOO_LONG;
            phase_d          = nmea_ck_pkg::PH_HUNT;
          end else begin
            xor_d   = xor_q ^ byte_i;
            count_d = count_q + 7'd1;
          end
        end
        nmea_ck_pkg::PH_HEX1: begin
          if (hex.bad) begin
            verdict_valid_o  = 1'b1;
            verdict_o.status = nmea_ck_pkg::ST_BAD_HEX;
            phase_d          = nmea_ck_pkg::PH_HUNT;
          end else begin
            nib_d   = hex.value;
            phase_d = nmea_ck_pkg::PH_HEX2;
          end
        end
        nmea_ck_pkg::PH_HEX2: begin
          verdict_valid_o = 1'b1;
          phase_d         = nmea_ck_pkg::PH_HUNT;
          if (hex.bad) begin
            verdict_o.status = nmea_ck_pkg::ST_BAD_HEX;
          end else begin
            verdict_o.received_sum = {nib_q, hex.value};
            verdict_o.status = ({nib_q, hex.value} == xor_q) ? nmea_ck_pkg::ST_OK
                                                             : nmea_ck_pkg::ST_MISMATCH;
          end
        end
        default: begin
          phase_d = nmea_ck_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nmea_ck_pkg::PH_HUNT;
      xor_q   <= 8'd0;
      count_q <= 7'd0;
      nib_q   <= 4'd0;
    end else begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      count_q <= count_d;
      nib_q   <= nib_d;
    end
  end

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register lost its one-hot code");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 7'(MAX_BODY))
    else $error("body counter ran past the limit");

  a_verdict_returns_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_valid_o |=> phase_q == nmea_ck_pkg::PH_HUNT)
    else $error("verdict did not send the block back to hunting");

endmodule

@@ rtl/nmea_checksum_checker.sv @@
`timescale 1ns / 1ps
// path: an accepted word waits in the input register and is processed from there; a verdict
//   it causes is registered in the verdict register before it shows on the output port
// throughput: one word per cycle, unless the verdict register holds a stalled verdict
// stalls: in_stall_o rises only when the input register holds a word and the
//   output register holds a verdict that is stalled
// reset: rst_ni clears the input and output valids and puts the checker in hunt
// nmea_checksum_checker: top level with input register and verdict register
// around the sentence state machine; uses nmea_ck_pkg and nmea_ck_core
module nmea_checksum_checker #(
  parameter int unsigned MAX_BODY = 80
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // received character stream
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // verdict stream, one word per sentence
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [7:0] computed_sum_o,
  output logic [7:0] received_sum_o,
  output logic [6:0] body_length_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // verdict register
  logic                  out_valid_q;
  nmea_ck_pkg::verdict_t out_q;

  logic                  step;
  logic                  verdict_valid;
  nmea_ck_pkg::verdict_t verdict;

  // the held word may advance once the verdict register is free or draining;
  // this holds whether or not the word produces a verdict
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  nmea_ck_core #(
    .MAX_BODY(MAX_BODY)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .byte_i         (in_byte_q),
    .verdict_valid_o(verdict_valid),
    .verdict_o      (verdict)
  );

  // verdict register: filled by a processed word, emptied when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && verdict_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && verdict_valid) begin
      out_q <= verdict;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign computed_sum_o = out_q.computed_sum;
  assign received_sum_o = out_q.received_sum;
  assign body_length_o  = out_q.body_length;

  // a matching verdict carries equal sums
  a_ok_sums_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == nmea_ck_pkg::ST_OK) |-> computed_sum_o == received_sum_o)
    else $error("ok verdict with differing sums");

  // failures before both digits report a zero received sum
  a_fail_zero_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == nmea_ck_pkg::ST_EARLY_END ||
                    status_o == nmea_ck_pkg::ST_TOO_LONG ||
                    status_o == nmea_ck_pkg::ST_BAD_HEX) |-> received_sum_o == 8'd0)
    else $error("failed verdict with nonzero received sum");

  // a stalled verdict is never overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !step)
    else $error("held word advanced into a stalled verdict register");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for nmea_checksum_checker, a directed table then random sentences
// checked word by word against a behavioral checksum predictor; uses nmea_ck_pkg
module tb_top;

  localparam int unsigned MaxBody     = 80;
  localparam int          LiveWords   = 950;   // random words that reach the sentence logic
  localparam int          CalmWords   = 150;   // tail of the run with no idling on either side
  localparam int          LongHoldAt  = 400;   // word count that triggers the long output hold
  localparam int          LongHold    = 60;
  localparam int          DrainCycles = 8;
  localparam int          IdleLimit   = 1000;  // cycles with no handshake on either channel
  localparam int          NumDirected = 29;

  // one stimulus word, with an optional typed-in verdict
  typedef struct packed {
    logic [7:0]            data;
    logic                  typed;
    nmea_ck_pkg::verdict_t want;
  } stim_row_t;

  // directed table: framing extremes, every status but too long, the special cases
  localparam stim_row_t DirectedRows [NumDirected] = '{
    // all-ones noise while hunting
    '{8'hFF,                1'b0, '0},
    '{nmea_ck_pkg::ChDollar, 1'b0, '0},
    // line end right after dollar
    '{nmea_ck_pkg::ChCr,     1'b1, '{nmea_ck_pkg::ST_EARLY_END, 8'h00, 8'h00, 7'd0}},
    '{nmea_ck_pkg::ChDollar, 1'b0, '0},
    // nul right after dollar
    '{nmea_ck_pkg::ChNul,    1'b1, '{nmea_ck_pkg::ST_EARLY_END, 8'h00, 8'h00, 7'd0}},
    '{nmea_ck_pkg::ChDollar, 1'b0, '0},
    '{nmea_ck_pkg::ChStar,   1'b0, '0},
    '{8'h30,                1'b0, '0},
    // empty body against zero
    '{8'h30,                1'b1, '{nmea_ck_pkg::ST_OK, 8'h00, 8'h00, 7'd0}},
    '{nmea_ck_pkg::ChDollar, 1'b0, '0},
    // all-ones body byte
    '{8'hFF,                1'b0, '0},
    // dollar inside body is data
    '{nmea_ck_pkg::ChDollar, 1'b0, '0},
    '{nmea_ck_pkg::ChStar,   1'b0, '0},
    // lowercase d
    '{8'h64,                1'b0, '0},
    // uppercase B, checksum ok
    '{8'h42,                1'b0, '0},
    '{nmea_ck_pkg::ChDollar, 1'b0, '0},
    '{8'h41,                1'b0, '0},
    '{nmea_ck_pkg::ChStar,   1'b0, '0},
    '{8'h34,                1'b0, '0},
    // off by one, mismatch
    '{8'h32,                1'b0, '0},
    '{nmea_ck_pkg::ChDollar, 1'b0, '0},
    '{nmea_ck_pkg::ChStar,   1'b0, '0},
    // G as first digit
    '{8'h47,                1'b1, '{nmea_ck_pkg::ST_BAD_HEX, 8'h00, 8'h00, 7'd0}},
    '{nmea_ck_pkg::ChDollar, 1'b0, '0},
    '{nmea_ck_pkg::ChStar,   1'b0, '0},
    '{8'h66,                1'b0, '0},
    // dollar as second digit
    '{nmea_ck_pkg::ChDollar, 1'b1, '{nmea_ck_pkg::ST_BAD_HEX, 8'h00, 8'h00, 7'd0}},
    '{nmea_ck_pkg::ChDollar, 1'b0, '0},
    // lf right after dollar
    '{nmea_ck_pkg::ChLf,     1'b1, '{nmea_ck_pkg::ST_EARLY_END, 8'h00, 8'h00, 7'd0}}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] status_o;
  logic [7:0] computed_sum_o;
  logic [7:0] received_sum_o;
  logic [6:0] body_length_o;

  stim_row_t             stim_q [$];
  nmea_ck_pkg::verdict_t verdict_q [$];  // verdicts still owed by the block, oldest first
  int                    drive_idx;      // row of the word currently on the input port
  int                    words_taken = 0;
  bit                    calm = 1'b0;
  int                    fail_cnt = 0;

  // checksum tracker state, mirrors the sentence parser
  nmea_ck_pkg::phase_e trk_phase;
  logic [7:0]          trk_xor;
  logic [6:0]          trk_count;
  logic [3:0]          trk_high;

  nmea_checksum_checker #(
    .MAX_BODY(MaxBody)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .computed_sum_o(computed_sum_o),
    .received_sum_o(received_sum_o),
    .body_length_o (body_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // bit 4 set means the byte is not a hex digit
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h37)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h57)};
    return 5'h10;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h57 : 8'h37) + 8'(n);
  endfunction

  function automatic stim_row_t plain_row(input logic [7:0] c);
    stim_row_t r;
    r       = '0;
    r.data  = c;
    return r;
  endfunction

  // advance the checksum tracker by one word; returns 1 when a verdict is due
  function automatic bit track_checksum(input logic [7:0] c,
                                        output nmea_ck_pkg::verdict_t v);
    logic [4:0]           d;
    bit                   done;
    nmea_ck_pkg::status_e st;
    logic [7:0]           rcv;
    d    = digit_value(c);
    done = 1'b0;
    st   = nmea_ck_pkg::ST_OK;
    rcv  = '0;
    case (trk_phase)
      nmea_ck_pkg::PH_HUNT: begin
        if (c == nmea_ck_pkg::ChDollar) begin
          trk_xor   = '0;
          trk_count = '0;
          trk_high  = '0;
          trk_phase = nmea_ck_pkg::PH_BODY;
        end
      end
      nmea_ck_pkg::PH_BODY: begin
        if (c == nmea_ck_pkg::ChStar) begin
          trk_phase = nmea_ck_pkg::PH_HEX1;
        end else if (c == nmea_ck_pkg::ChCr || c == nmea_ck_pkg::ChLf ||
                     c == nmea_ck_pkg::ChNul) begin
          done = 1'b1;
          st   = nmea_ck_pkg::ST_EARLY_END;
        end else if (int'(trk_count) >= MaxBody) begin
          // over the limit: this byte is dropped, not summed
          done = 1'b1;
          st   = nmea_ck_pkg::ST_TOO_LONG;
        end else begin
          trk_xor   = trk_xor ^ c;
          trk_count = trk_count + 7'd1;
        end
      end
      nmea_ck_pkg::PH_HEX1: begin
        if (d[4]) begin
          done = 1'b1;
          st   = nmea_ck_pkg::ST_BAD_HEX;
        end else begin
          trk_high  = d[3:0];
          trk_phase = nmea_ck_pkg::PH_HEX2;
        end
      end
      default: begin
        if (d[4]) begin
          done = 1'b1;
          st   = nmea_ck_pkg::ST_BAD_HEX;
        end else begin
          rcv  = {trk_high, d[3:0]};
          done = 1'b1;
          st   = (rcv == trk_xor) ? nmea_ck_pkg::ST_OK : nmea_ck_pkg::ST_MISMATCH;
        end
      end
    endcase
    v.status       = st;
    v.computed_sum = trk_xor;
    v.received_sum = rcv;
    v.body_length  = trk_count;
    if (done) trk_phase = nmea_ck_pkg::PH_HUNT;
    return done;
  endfunction

  // stimulus build, reset, byte source and end of run
  initial begin : byte_source
    int         gap_left;
    int         live;
    int         len;
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] sent_sum;
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    logic [4:0] d;
    bit         cut;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i  = '0;
    drive_idx  = 0;
    gap_left   = 0;
    live       = 0;
    trk_phase  = nmea_ck_pkg::PH_HUNT;
    trk_xor    = '0;
    trk_count  = '0;
    trk_high   = '0;

    foreach (DirectedRows[k]) stim_q.push_back(DirectedRows[k]);

    // random part: mostly well-formed sentences with random bodies, plus line
    // noise, early line ends, wrong checksums, bad digits and overlong bodies
    while (live < LiveWords) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 3)) stim_q.push_back(plain_row(8'($urandom_range(0, 255))));
      end else begin
        stim_q.push_back(plain_row(nmea_ck_pkg::ChDollar));
        live++;
        if ($urandom_range(0, 15) == 0) len = $urandom_range(76, 84);
        else len = $urandom_range(0, 14);
        sum = '0;
        cut = 1'b0;
        for (int i = 0; i < len && !cut; i++) begin
          if ($urandom_range(0, 59) == 0) begin
            // broken sentence: line end inside the body
            case ($urandom_range(0, 2))
              0:       b = nmea_ck_pkg::ChCr;
              1:       b = nmea_ck_pkg::ChLf;
              default: b = nmea_ck_pkg::ChNul;
            endcase
            cut = 1'b1;
          end else begin
            do b = 8'($urandom_range(0, 255));
            while (b == nmea_ck_pkg::ChStar || b == nmea_ck_pkg::ChCr ||
                   b == nmea_ck_pkg::ChLf || b == nmea_ck_pkg::ChNul);
            sum = sum ^ b;
          end
          stim_q.push_back(plain_row(b));
          live++;
        end
        if (!cut) begin
          stim_q.push_back(plain_row(nmea_ck_pkg::ChStar));
          sent_sum = ($urandom_range(0, 3) != 0) ? sum : 8'($urandom_range(0, 255));
          hi_c     = digit_char(sent_sum[7:4], 1'($urandom_range(0, 1)));
          lo_c     = digit_char(sent_sum[3:0], 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 19) == 0) begin
            do begin
              b = 8'($urandom_range(0, 255));
              d = digit_value(b);
            end while (!d[4]);
            if ($urandom_range(0, 1) == 0) hi_c = b;
            else lo_c = b;
          end
          stim_q.push_back(plain_row(hi_c));
          stim_q.push_back(plain_row(lo_c));
          live += 3;
          if ($urandom_range(0, 1) == 0) begin
            stim_q.push_back(plain_row(nmea_ck_pkg::ChCr));
            stim_q.push_back(plain_row(nmea_ck_pkg::ChLf));
          end
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // a stalled word holds; otherwise move on, with random gap bursts
    while (words_taken < stim_q.size()) begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) words_taken++;
      calm = (words_taken + CalmWords >= stim_q.size());
      if (!(in_valid_i && in_stall_o)) begin
        if (words_taken == stim_q.size()) begin
          in_valid_i <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= stim_q[words_taken].data;
          drive_idx  <= words_taken;
        end
      end
    end

    // wait for every owed verdict, then a few cycles for strays
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // verdict sink: short random stall bursts, one long hold to back the block up
  initial begin : verdict_sink
    int hold_left;
    bit long_done;
    hold_left   = 0;
    long_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!long_done && words_taken >= LongHoldAt) begin
        long_done = 1'b1;
        hold_left = LongHold - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // predict on every accepted word, compare every accepted verdict
  always @(posedge clk_i) begin : verdict_check
    nmea_ck_pkg::verdict_t pred;
    nmea_ck_pkg::verdict_t want;
    stim_row_t             row;
    bit                    due;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        row = stim_q[drive_idx];
        due = track_checksum(rx_byte_i, pred);
        // typed-in rows take precedence, the tracker still advances
        if (row.typed) verdict_q.push_back(row.want);
        else if (due) verdict_q.push_back(pred);
      end
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $error("verdict with none owed: status %0d sum %02h", status_o, computed_sum_o);
          fail_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fail_cnt++;
          end
          if (computed_sum_o !== want.computed_sum) begin
            $error("computed_sum: expected %02h, got %02h", want.computed_sum, computed_sum_o);
            fail_cnt++;
          end
          if (received_sum_o !== want.received_sum) begin
            $error("received_sum: expected %02h, got %02h", want.received_sum, received_sum_o);
            fail_cnt++;
          end
          if (body_length_o !== want.body_length) begin
            $error("body_length: expected %0d, got %0d", want.body_length, body_length_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  // watchdog: too long with no handshake on either channel
  always @(posedge clk_i) begin : idle_watch
    int idle_cnt;
    if (!rst_ni) begin
      idle_cnt = 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

@@ sim.f @@
rtl/nmea_ck_pkg.sv
rtl/nmea_ck_core.sv
rtl/nmea_checksum_checker.sv
sim/tb_top.sv
